// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, prop)
`endif
`endif

// ===== rtl/scbm_pkg.sv =====
package scbm_pkg;

   // default sizes
   localparam int MAX_COLUMNS_DEF = 256;
   localparam int MAX_ROWS_DEF    = 64;

   // field widths
   localparam int COL_W      = 8;
   localparam int MAG_W      = 16;
   localparam int TROW_W     = 6;
   localparam int ROW_W      = 7;
   localparam int FALL_W     = 11;
   localparam int FADE_W     = 8;
   localparam int FRAC_W     = 8;
   localparam int LEVEL_W    = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // register reset values
   localparam logic [ROW_W-1:0]  ROWS_RESET = 7'd16;
   localparam logic [FALL_W-1:0] FALL_RESET = 11'd256;
   localparam logic [FADE_W-1:0] FADE_RESET = 8'd90;

   // column state reset values
   localparam logic [ROW_W-1:0]  PEAK_INIT  = 7'd50;
   localparam logic [FADE_W-1:0] COUNT_INIT = 8'd32;

   typedef enum logic {
      REQ_TABLE  = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_IN_USE = 2'd0,
      CSR_FALL_STEP   = 2'd1,
      CSR_FADE_LENGTH = 2'd2
   } csr_index_type;

   // per-column state word
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [ROW_W-1:0]   peak;
      logic [FADE_W-1:0]  count;
   } col_state_type;

   localparam col_state_type STATE_INIT = '{level: '0, peak: PEAK_INIT, count: COUNT_INIT};

endpackage

// ===== rtl/spectrum_column_bar_meter.sv =====
// a sample beat passes stages a, b, c and the result register; takes one beat per cycle
// unless a result beat is held; a table write or out-of-range column uses a slot, no result
// column state memory is read one stage before the update stage, write-back is forwarded
// reset (synchronous, active high): clears stage and column valid bits, presets registers;
// columns then read as level 0, peak row 50, fade count 32; thresholds undefined until written
`include "assert_macros.svh"

module spectrum_column_bar_meter #(
   parameter int MAX_COLUMNS = scbm_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = scbm_pkg::MAX_ROWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_write,
   input  logic [scbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scbm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [scbm_pkg::COL_W-1:0]       req_column_index,
   input  logic [scbm_pkg::MAG_W-1:0]       req_magnitude,
   input  logic [scbm_pkg::TROW_W-1:0]      req_table_row,
   input  logic [scbm_pkg::MAG_W-1:0]       req_table_value,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [scbm_pkg::COL_W-1:0]       rsp_out_column,
   output logic [scbm_pkg::ROW_W-1:0]       rsp_bar_level,
   output logic                             rsp_fade_visible,
   output logic [scbm_pkg::ROW_W-1:0]       rsp_fade_row,
   output logic [scbm_pkg::FADE_W-1:0]      rsp_fade_shade
);

   localparam int IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // configuration registers
   logic [scbm_pkg::ROW_W-1:0]  rows_ff;
   logic [scbm_pkg::FALL_W-1:0] fall_ff;
   logic [scbm_pkg::FADE_W-1:0] fade_ff;
   logic [scbm_pkg::ROW_W-1:0]  rows_eff;

   // threshold table, no reset
   logic [scbm_pkg::MAG_W-1:0]  thr_ff [MAX_ROWS];

   // column state memory and its valid bits
   scbm_pkg::col_state_type     state_mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0]      col_vld_ff;

   // pipeline control
   logic                        adv;
   logic                        req_accept;
   logic                        sample_in;

   // stage a: compare results
   logic                        a_vld_ff;
   logic [scbm_pkg::COL_W-1:0]  a_col_ff;
   logic [MAX_ROWS-1:0]         a_hits_ff;
   logic [MAX_ROWS-1:0]         hits_in;
   logic [IDX_W-1:0]            a_idx;

   // stage b: blank-row count and state read
   logic                        b_vld_ff;
   logic [scbm_pkg::COL_W-1:0]  b_col_ff;
   logic [scbm_pkg::ROW_W-1:0]  b_y_ff;
   logic [scbm_pkg::ROW_W-1:0]  b_y_in;
   scbm_pkg::col_state_type     b_rd_ff;
   logic                        b_init_ff;
   logic                        b_fwd_ff;
   scbm_pkg::col_state_type     b_fwd_data_ff;
   scbm_pkg::col_state_type     b_state;
   logic [IDX_W-1:0]            b_idx;

   // stage c: state update
   logic                        c_vld_ff;
   logic [scbm_pkg::COL_W-1:0]  c_col_ff;
   logic [scbm_pkg::ROW_W-1:0]  c_y_ff;
   scbm_pkg::col_state_type     c_state_ff;
   scbm_pkg::col_state_type     c_state_in;
   logic [IDX_W-1:0]            c_idx;

   // update datapath
   logic [scbm_pkg::LEVEL_W-1:0] lvl_y;
   logic [scbm_pkg::LEVEL_W-1:0] lvl_cap;
   logic [scbm_pkg::LEVEL_W:0]   lvl_sum;
   logic [scbm_pkg::LEVEL_W-1:0] lvl_new;
   logic [scbm_pkg::ROW_W-1:0]   bar_y;
   logic [scbm_pkg::ROW_W-1:0]   pk_new;
   logic [scbm_pkg::FADE_W-1:0]  cnt_new;
   logic                         vis_in;
   logic [scbm_pkg::ROW_W-1:0]   frow_in;
   logic [scbm_pkg::FADE_W-1:0]  shade_in;
   scbm_pkg::col_state_type      wb_state_in;

   // result registers
   logic                         rsp_valid_ff;
   logic [scbm_pkg::COL_W-1:0]   rsp_col_ff;
   logic [scbm_pkg::ROW_W-1:0]   rsp_bar_ff;
   logic                         rsp_vis_ff;
   logic [scbm_pkg::ROW_W-1:0]   rsp_frow_ff;
   logic [scbm_pkg::FADE_W-1:0]  rsp_shade_ff;

   // whole pipeline moves together unless a result beat is held
   assign adv        = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !adv;
   assign req_accept = req_valid && adv;
   assign sample_in  = req_accept && (req_type == scbm_pkg::REQ_SAMPLE)
                       && (int'(req_column_index) < MAX_COLUMNS);

   assign a_idx = IDX_W'(a_col_ff);
   assign b_idx = IDX_W'(b_col_ff);
   assign c_idx = IDX_W'(c_col_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= scbm_pkg::ROWS_RESET;
         fall_ff <= scbm_pkg::FALL_RESET;
         fade_ff <= scbm_pkg::FADE_RESET;
      end else if (csr_write) begin
         unique case (scbm_pkg::csr_index_type'(csr_index))
            scbm_pkg::CSR_ROWS_IN_USE: rows_ff <= csr_wdata[scbm_pkg::ROW_W-1:0];
            scbm_pkg::CSR_FALL_STEP:   fall_ff <= csr_wdata[scbm_pkg::FALL_W-1:0];
            scbm_pkg::CSR_FADE_LENGTH: fade_ff <= csr_wdata[scbm_pkg::FADE_W-1:0];
            default: ;
         endcase
      end
   end

   // row count clamped to 1..MAX_ROWS
   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = scbm_pkg::ROW_W'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         rows_eff = scbm_pkg::ROW_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
   end

   // threshold table write
   always_ff @(posedge clock) begin
      if (req_accept && (req_type == scbm_pkg::REQ_TABLE)
          && (int'(req_table_row) < MAX_ROWS)) begin
         thr_ff[RIDX_W'(req_table_row)] <= req_table_value;
      end
   end

   // parallel threshold compares, rows beyond the row count masked
   always_comb begin
      for (int z = 0; z < MAX_ROWS; z++) begin
         hits_in[z] = (req_magnitude >= thr_ff[z]) && (z < int'(rows_eff));
      end
   end

   // first reached row, or the row count if none
   always_comb begin
      b_y_in = rows_eff;
      for (int z = MAX_ROWS - 1; z >= 0; z--) begin
         if (a_hits_ff[z]) begin
            b_y_in = scbm_pkg::ROW_W'(z);
         end
      end
   end

   // state seen in stage b: forwarded write, stored word or reset value
   always_comb begin
      if (b_fwd_ff) begin
         b_state = b_fwd_data_ff;
      end else if (b_init_ff) begin
         b_state = b_rd_ff;
      end else begin
         b_state = scbm_pkg::STATE_INIT;
      end
   end

   // bypass from the write-back for back-to-back beats of one column
   always_comb begin
      if (c_vld_ff && (c_idx == b_idx)) begin
         c_state_in = wb_state_in;
      end else begin
         c_state_in = b_state;
      end
   end

   // falling level, peak row and fade countdown
   always_comb begin
      lvl_y   = {c_y_ff, {scbm_pkg::FRAC_W{1'b0}}};
      lvl_cap = {rows_eff, {scbm_pkg::FRAC_W{1'b0}}};
      lvl_sum = {1'b0, c_state_ff.level} + (scbm_pkg::LEVEL_W + 1)'(fall_ff);
      if (lvl_y > c_state_ff.level) begin
         if (lvl_sum > {1'b0, lvl_cap}) begin
            lvl_new = lvl_cap;
         end else begin
            lvl_new = lvl_sum[scbm_pkg::LEVEL_W-1:0];
         end
      end else begin
         lvl_new = lvl_y;
      end
      bar_y = lvl_new[scbm_pkg::LEVEL_W-1:scbm_pkg::FRAC_W];

      pk_new  = c_state_ff.peak;
      cnt_new = c_state_ff.count;
      if (bar_y <= pk_new) begin
         pk_new  = bar_y;
         cnt_new = fade_ff;
      end
      vis_in   = 1'b0;
      frow_in  = '0;
      shade_in = '0;
      if (cnt_new != '0) begin
         cnt_new  = cnt_new - scbm_pkg::FADE_W'(1);
         vis_in   = 1'b1;
         frow_in  = pk_new;
         shade_in = cnt_new;
      end
      if (cnt_new == '0) begin
         pk_new = rows_eff;
      end
      wb_state_in = '{level: lvl_new, peak: pk_new, count: cnt_new};
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff     <= sample_in;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         rsp_valid_ff <= c_vld_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         a_col_ff  <= req_column_index;
         a_hits_ff <= hits_in;
         b_col_ff  <= a_col_ff;
         b_y_ff    <= b_y_in;
         c_col_ff  <= b_col_ff;
         c_y_ff    <= b_y_ff;
         c_state_ff <= c_state_in;
      end
   end

   // state read one stage ahead, with a note of a write at the same edge
   always_ff @(posedge clock) begin
      if (adv && a_vld_ff) begin
         b_rd_ff       <= state_mem[a_idx];
         b_init_ff     <= col_vld_ff[a_idx];
         b_fwd_ff      <= c_vld_ff && (c_idx == a_idx);
         b_fwd_data_ff <= wb_state_in;
      end
   end

   // state write-back
   always_ff @(posedge clock) begin
      if (adv && c_vld_ff) begin
         state_mem[c_idx] <= wb_state_in;
      end
   end

   // column valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         col_vld_ff <= '0;
      end else if (adv && c_vld_ff) begin
         col_vld_ff[c_idx] <= 1'b1;
      end
   end

   // result beat
   always_ff @(posedge clock) begin
      if (adv && c_vld_ff) begin
         rsp_col_ff   <= c_col_ff;
         rsp_bar_ff   <= bar_y;
         rsp_vis_ff   <= vis_in;
         rsp_frow_ff  <= frow_in;
         rsp_shade_ff <= shade_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_column   = rsp_col_ff;
   assign rsp_bar_level    = rsp_bar_ff;
   assign rsp_fade_visible = rsp_vis_ff;
   assign rsp_fade_row     = rsp_frow_ff;
   assign rsp_fade_shade   = rsp_shade_ff;

   // checks
   `ASSERT_CLK(a_rsp_from_update, clock, reset, $rose(rsp_valid_ff) |-> $past(c_vld_ff))
   `ASSERT_CLK(a_fade_idle_zero, clock, reset, (rsp_valid_ff && !rsp_vis_ff) |-> (rsp_frow_ff == '0 && rsp_shade_ff == '0))
   `ASSERT_NEVER(a_shade_full, clock, reset, rsp_valid_ff && rsp_vis_ff && (rsp_shade_ff == '1))
   `ASSERT_CLK(a_bypass_newest, clock, reset, (adv && b_vld_ff && c_vld_ff && (b_idx == c_idx)) |=> (c_state_ff == $past(wb_state_in)))

endmodule

// ===== verif/spectrum_column_bar_meter_tb.sv =====
module spectrum_column_bar_meter_tb;
   import scbm_pkg::*;

   localparam int RESULT_LATENCY = 3;
   localparam int LONG_HOLD      = 60;

   // one result beat as the block presents it
   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  bar;
      logic              visible;
      logic [ROW_W-1:0]  fade_row;
      logic [FADE_W-1:0] shade;
   } bar_beat_type;

   // column state mirror and queue of bars still owed by the block
   class column_meter_board;
      int unsigned       rows_cfg;
      int unsigned       fall_cfg;
      int unsigned       fade_cfg;
      logic [MAG_W-1:0]   thresholds [MAX_ROWS_DEF];
      logic [LEVEL_W-1:0] level_q8 [MAX_COLUMNS_DEF];
      logic [ROW_W-1:0]   peak_at [MAX_COLUMNS_DEF];
      logic [FADE_W-1:0]  fade_left [MAX_COLUMNS_DEF];
      bar_beat_type       owed_bars [$];
      int unsigned        mismatches;

      function new();
         rows_cfg   = ROWS_RESET;
         fall_cfg   = FALL_RESET;
         fade_cfg   = FADE_RESET;
         mismatches = 0;
         for (int r = 0; r < MAX_ROWS_DEF; r++) thresholds[r] = '0;
         for (int c = 0; c < MAX_COLUMNS_DEF; c++) begin
            level_q8[c]  = '0;
            peak_at[c]   = PEAK_INIT;
            fade_left[c] = COUNT_INIT;
         end
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ROWS_IN_USE: rows_cfg = value[ROW_W-1:0];
            CSR_FALL_STEP:   fall_cfg = value[FALL_W-1:0];
            CSR_FADE_LENGTH: fade_cfg = value[FADE_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_bars.size();
      endfunction

      // accepted request: table write or column frame update
      function void note_request(logic kind, logic [COL_W-1:0] col, logic [MAG_W-1:0] mag,
                                 logic [TROW_W-1:0] trow, logic [MAG_W-1:0] tval);
         int unsigned  rows;
         int unsigned  y;
         int unsigned  lvl;
         int unsigned  cap;
         int unsigned  pk;
         int unsigned  cnt;
         bit           found;
         bar_beat_type want;
         if (kind == REQ_TABLE) begin
            thresholds[trow] = tval;
            return;
         end
         rows = rows_cfg;
         if (rows == 0) rows = 1;
         if (rows > MAX_ROWS_DEF) rows = MAX_ROWS_DEF;
         // first row whose threshold the magnitude reaches
         y = rows;
         found = 1'b0;
         for (int z = 0; z < rows; z++) begin
            if (!found && mag >= thresholds[z]) begin
               y = z;
               found = 1'b1;
            end
         end
         // bar falls slowly, rises at once
         lvl = level_q8[col];
         cap = rows << FRAC_W;
         if ((y << FRAC_W) > lvl) begin
            lvl = lvl + fall_cfg;
            if (lvl > cap) lvl = cap;
            y = lvl >> FRAC_W;
         end else begin
            lvl = y << FRAC_W;
         end
         level_q8[col] = LEVEL_W'(lvl);
         // peak marker and its fade countdown
         want = '0;
         want.column = col;
         want.bar = ROW_W'(y);
         pk  = peak_at[col];
         cnt = fade_left[col];
         if (y <= pk) begin
            pk  = y;
            cnt = fade_cfg;
         end
         if (cnt > 0) begin
            cnt = cnt - 1;
            want.visible  = 1'b1;
            want.fade_row = ROW_W'(pk);
            want.shade    = FADE_W'(cnt);
         end
         if (cnt == 0) pk = rows;
         peak_at[col]   = ROW_W'(pk);
         fade_left[col] = FADE_W'(cnt);
         owed_bars.push_back(want);
      endfunction

      function void report(string what, bar_beat_type want, bar_beat_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s: expected col %0d bar %0d vis %0d row %0d shade %0d, got col %0d bar %0d vis %0d row %0d shade %0d",
                     $time, what, want.column, want.bar, want.visible, want.fade_row,
                     want.shade, got.column, got.bar, got.visible, got.fade_row, got.shade);
      endfunction

      function void check_result(bar_beat_type got);
         bar_beat_type want;
         if (owed_bars.size() == 0) begin
            report("bar beat with none owed", '0, got);
            return;
         end
         want = owed_bars.pop_front();
         if (got.column !== want.column || got.bar !== want.bar ||
             got.visible !== want.visible || got.fade_row !== want.fade_row ||
             got.shade !== want.shade)
            report("bar beat mismatch", want, got);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_type;
   logic [COL_W-1:0]        req_column_index;
   logic [MAG_W-1:0]        req_magnitude;
   logic [TROW_W-1:0]       req_table_row;
   logic [MAG_W-1:0]        req_table_value;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [COL_W-1:0]        rsp_out_column;
   logic [ROW_W-1:0]        rsp_bar_level;
   logic                    rsp_fade_visible;
   logic [ROW_W-1:0]        rsp_fade_row;
   logic [FADE_W-1:0]       rsp_fade_shade;

   column_meter_board board;
   bit                quiet;
   int unsigned       hold_requests = 0;
   int unsigned       rows_now;
   int unsigned       col_base;
   logic [MAG_W-1:0]  thr_shadow [MAX_ROWS_DEF];

   spectrum_column_bar_meter DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_column_index (req_column_index),
      .req_magnitude    (req_magnitude),
      .req_table_row    (req_table_row),
      .req_table_value  (req_table_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_column   (rsp_out_column),
      .rsp_bar_level    (rsp_bar_level),
      .rsp_fade_visible (rsp_fade_visible),
      .rsp_fade_row     (rsp_fade_row),
      .rsp_fade_shade   (rsp_fade_shade)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watch both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(req_type, req_column_index, req_magnitude,
                               req_table_row, req_table_value);
         if (rsp_valid && !rsp_stall)
            board.check_result({rsp_out_column, rsp_bar_level, rsp_fade_visible,
                                rsp_fade_row, rsp_fade_shade});
      end
   end

   // result side: random stalls plus an occasional long hold-off
   initial begin : result_side
      int unsigned hold_left;
      int unsigned holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (!quiet && $urandom_range(99) < 8);
         end
      end
   end

   initial begin : watchdog
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // one request beat, held until accepted
   task automatic send_beat(logic kind, logic [COL_W-1:0] col, logic [MAG_W-1:0] mag,
                            logic [TROW_W-1:0] trow, logic [MAG_W-1:0] tval);
      while (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_column_index <= col;
      req_magnitude    <= mag;
      req_table_row    <= trow;
      req_table_value  <= tval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_sample(logic [COL_W-1:0] col, logic [MAG_W-1:0] mag);
      send_beat(REQ_SAMPLE, col, mag, TROW_W'($urandom_range(63)),
                MAG_W'($urandom_range(65535)));
   endtask

   task automatic send_threshold(int unsigned row, logic [MAG_W-1:0] value);
      thr_shadow[row] = value;
      send_beat(REQ_TABLE, COL_W'($urandom_range(255)), MAG_W'($urandom_range(65535)),
                TROW_W'(row), value);
   endtask

   // stop offering and wait for every owed bar, then let the pipe settle
   task automatic drain_results(int unsigned settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // non-increasing threshold ladder over all rows
   task automatic load_thresholds(bit shaped);
      int unsigned level_v;
      int unsigned step_v;
      level_v = shaped ? $urandom_range(65535, 30000) : 65535;
      for (int z = 0; z < MAX_ROWS_DEF; z++) begin
         send_threshold(z, MAG_W'(level_v));
         step_v = shaped ? $urandom_range(1400, 0) : 1024;
         level_v = (level_v > step_v) ? level_v - step_v : 0;
      end
   endtask

   // display settings, written only with the pipe empty
   task automatic set_display(int unsigned rows, int unsigned fall, int unsigned fade);
      drain_results(RESULT_LATENCY + 3);
      csr_write <= 1'b1;
      csr_index <= CSR_ROWS_IN_USE;
      csr_wdata <= CSR_DATA_W'(rows);
      @(posedge clock);
      board.set_register(CSR_ROWS_IN_USE, CSR_DATA_W'(rows));
      csr_index <= CSR_FALL_STEP;
      csr_wdata <= CSR_DATA_W'(fall);
      @(posedge clock);
      board.set_register(CSR_FALL_STEP, CSR_DATA_W'(fall));
      csr_index <= CSR_FADE_LENGTH;
      csr_wdata <= CSR_DATA_W'(fade);
      @(posedge clock);
      board.set_register(CSR_FADE_LENGTH, CSR_DATA_W'(fade));
      csr_write <= 1'b0;
      rows_now = (rows == 0) ? 1 : (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
   endtask

   // mostly frames on a few neighbouring columns, magnitudes often near thresholds
   task automatic random_beat();
      int unsigned pick;
      int unsigned z;
      int          m;
      logic [COL_W-1:0] col;
      pick = $urandom_range(99);
      if (pick < 4) begin
         send_threshold($urandom_range(63), MAG_W'($urandom_range(65535)));
      end else begin
         if ($urandom_range(99) < 75) col = COL_W'(col_base + $urandom_range(5));
         else col = COL_W'($urandom_range(255));
         pick = $urandom_range(99);
         if (pick < 45) begin
            z = $urandom_range(rows_now);
            if (z >= MAX_ROWS_DEF) z = MAX_ROWS_DEF - 1;
            m = int'(thr_shadow[z]) + int'($urandom_range(2)) - 1;
            if (m < 0) m = 0;
            if (m > 65535) m = 65535;
         end else if (pick < 60) begin
            m = 0;
         end else if (pick < 68) begin
            m = 65535;
         end else begin
            m = $urandom_range(65535);
         end
         send_sample(col, MAG_W'(m));
      end
   endtask

   initial begin : stimulus
      int unsigned pick;
      reset            = 1'b1;
      csr_write        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_type         = REQ_TABLE;
      req_column_index = '0;
      req_magnitude    = '0;
      req_table_row    = '0;
      req_table_value  = '0;
      quiet            = 1'b0;
      rows_now         = ROWS_RESET;
      col_base         = 0;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // linear ladder: row z threshold is full scale minus z*1024
      load_thresholds(1'b0);

      // reset settings: full scale, zero, exact threshold and one below
      send_sample(0, 16'hFFFF);
      send_sample(0, 16'h0000);
      send_sample(0, 16'h0000);
      send_sample(255, 16'h0000);
      send_sample(255, 16'hF3FF);
      send_sample(255, 16'hF3FE);
      send_sample(17, 16'hFFFE);
      send_sample(128, 16'hC3FF);
      send_sample(128, 16'hC3FE);

      // row count zero acts as one, fade length zero never draws
      set_display(0, 2047, 0);
      send_sample(0, 16'hFFFF);
      send_sample(0, 16'h0000);
      send_sample(5, 16'hFFFE);

      // full height, fastest fall, bottom row threshold
      set_display(64, 2047, 1);
      send_sample(200, 16'h0000);
      send_sample(200, 16'h0000);
      send_sample(200, 16'h0000);
      send_sample(0, 16'h03FF);
      send_sample(0, 16'h0000);

      // shrunken row count with a level above it, and no fall at all
      set_display(4, 0, 255);
      send_sample(200, 16'h0000);
      send_sample(3, 16'hFFFF);
      send_sample(3, 16'h0000);

      // random phases over several display settings
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_display(16, 256, 90);
            1: set_display(64, 2047, 255);
            2: set_display(1, 0, 1);
            3: set_display(127, 1, 0);
            default: begin
               pick = $urandom_range(9);
               set_display(pick == 0 ? 0 : pick == 1 ? $urandom_range(127, 65)
                           : $urandom_range(64, 1),
                           $urandom_range(1) ? $urandom_range(300) : $urandom_range(2047),
                           $urandom_range(9) == 0 ? 0 : $urandom_range(40, 1));
            end
         endcase
         quiet = (phase == 3);
         col_base = $urandom_range(250);
         if (phase % 2 == 0) load_thresholds(1'b1);
         for (int i = 0; i < 164; i++) begin
            // block the result side while requests keep coming
            if (i == 80 && (phase == 1 || phase == 5)) hold_requests++;
            if (i == 100 && phase == 2) drain_results(0);
            random_beat();
         end
         quiet = 1'b0;
      end

      drain_results(RESULT_LATENCY + 6);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
